// ===== hw/rtl/brcts_pkg.sv =====
package brcts_pkg;

    // Defaults for the top-level parameters
    localparam int ENTRIES_DEF   = 256;
    localparam int ADDR_BITS_DEF = 40;

    // Fixed field widths of the channels
    localparam int CMD_W    = 2;
    localparam int OFFSET_W = 40;
    localparam int WAY_W    = 8;
    localparam int SHIFT_W  = 5;

    localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd12;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FILL   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INVAL  = 2'd2;

    // Replacement LFSR (Galois, shifts right)
    localparam int               LFSR_W    = 16;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h0001;

endpackage

// ===== hw/rtl/brcts_if.sv =====
// Request channel: one command on one byte offset
interface brcts_req_if
    import brcts_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [OFFSET_W-1:0] offset;

    modport source (output valid, output cmd, output offset, input ready);
    modport sink   (input valid, input cmd, input offset, output ready);
endinterface

// Response channel: one result per request
interface brcts_rsp_if
    import brcts_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             hit;
    logic [WAY_W-1:0] way;
    logic             misaligned;

    modport source (output valid, output hit, output way, output misaligned, input ready);
    modport sink   (input valid, input hit, input way, input misaligned, output ready);
endinterface

// ===== hw/rtl/brcts_tag_ram.sv =====
module brcts_tag_ram
    import brcts_pkg::*;
#(
    parameter int DEPTH = ENTRIES_DEF,
    parameter int WIDTH = ADDR_BITS_DEF + 1,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/brcts_repl.sv =====
module brcts_repl
    import brcts_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF,
    localparam int IDX_W  = $clog2(ENTRIES)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             done,
    output logic [IDX_W-1:0] pick
);

    // Reciprocal of ENTRIES scaled by 2^RCP_SH, rounded down: the quotient
    // estimate is at most one short, so one compare and subtract fixes it
    localparam int RCP_SH = LFSR_W + IDX_W;
    localparam int RCP_W  = LFSR_W + 1;
    localparam int PROD_W = LFSR_W + RCP_W;
    localparam logic [RCP_W-1:0]  RCP_MUL = RCP_W'((64'd1 << RCP_SH) / 64'(ENTRIES));
    localparam logic [LFSR_W-1:0] DIVISOR = LFSR_W'(ENTRIES);

    logic [LFSR_W-1:0] lfsr_reg;
    logic [LFSR_W-1:0] lfsr_next;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] prod_reg;
    logic [LFSR_W-1:0] x_reg;
    logic [LFSR_W-1:0] quot;
    logic [LFSR_W-1:0] quot_mul;
    logic [LFSR_W-1:0] rem_reg;
    logic [LFSR_W-1:0] rem_fix;
    logic [IDX_W-1:0]  pick_reg;
    logic              mul_vld_reg;
    logic              rem_vld_reg;
    logic              done_reg;

    // Galois step: shift right, fold taps in on a one out
    assign lfsr_next = {1'b0, lfsr_reg[LFSR_W-1:1]}
                     ^ (lfsr_reg[0] ? LFSR_TAPS : '0);

    // LFSR mod ENTRIES: multiply, back-multiply and subtract, then correct
    assign prod     = PROD_W'(lfsr_reg) * PROD_W'(RCP_MUL);
    assign quot     = LFSR_W'(prod_reg >> RCP_SH);
    assign quot_mul = LFSR_W'(quot * DIVISOR);
    assign rem_fix  = (rem_reg >= DIVISOR) ? (rem_reg - DIVISOR) : rem_reg;

    // Control and LFSR state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg    <= LFSR_SEED;
            mul_vld_reg <= 1'b0;
            rem_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                lfsr_reg <= lfsr_next;
            end
            mul_vld_reg <= start;
            rem_vld_reg <= mul_vld_reg;
            done_reg    <= rem_vld_reg;
        end
    end

    // Remainder datapath, three stages
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= lfsr_reg;
            prod_reg <= prod;
        end
        if (mul_vld_reg)
        begin
            rem_reg <= x_reg - quot_mul;
        end
        if (rem_vld_reg)
        begin
            pick_reg <= rem_fix[IDX_W-1:0];
        end
    end

    assign done = done_reg;
    assign pick = pick_reg;

endmodule

// ===== hw/rtl/block_read_cache_tag_store.sv =====
// Lookup and invalidate scan the tag RAM from way 0; an invalidate scans every way;
//   a lookup stops at the first hit, a fill at the first free way.
// Fill with every way valid: the victim is the LFSR mod ENTRIES, by reciprocal multiply.
// Misaligned invalidate or unused command: no scan, straight to the result.
// One item at a time; the scan reads one tag RAM entry per cycle.
// Reset: a clearing pass writes every tag RAM entry with req.ready low; block_shift 12.
module block_read_cache_tag_store
    import brcts_pkg::*;
#(
    parameter int ENTRIES   = ENTRIES_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    brcts_req_if.sink          req,
    brcts_rsp_if.source        rsp,
    input  logic               cfg_we,
    input  logic [SHIFT_W-1:0] cfg_wdata
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int MW    = ADDR_BITS + 1;
    localparam int WAY_X = (IDX_W > WAY_W) ? IDX_W : WAY_W;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_MOD   = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W:0]     rd_cnt_reg, rd_cnt_next;
    logic               chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]   chk_idx_reg;
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [ADDR_BITS-1:0] tag_reg, tag_next;
    logic               res_hit_reg, res_hit_next;
    logic [IDX_W-1:0]   res_way_reg, res_way_next;
    logic               res_mis_reg, res_mis_next;
    logic [SHIFT_W-1:0] shift_reg;

    logic               out_vld_reg;
    logic               out_hit_reg;
    logic [WAY_W-1:0]   out_way_reg;
    logic               out_mis_reg;
    logic               out_free;
    logic               out_load;
    logic [WAY_X-1:0]   way_x;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [MW-1:0]      mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;
    logic [MW-1:0]      mem_rdata;

    logic               repl_start;
    logic               repl_done;
    logic [IDX_W-1:0]   repl_pick;

    logic [ADDR_BITS-1:0] acc_off;
    logic [ADDR_BITS-1:0] acc_mask;
    logic [ADDR_BITS-1:0] acc_tag;
    logic               rd_valid;
    logic [ADDR_BITS-1:0] rd_tag;
    logic               rd_match;
    logic               chk_last;
    logic               scan_more;

    // Tag RAM: {valid, tag} per way
    brcts_tag_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (MW)
    ) u_tag_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Victim choice when every way is valid
    brcts_repl #(
        .ENTRIES (ENTRIES)
    ) u_repl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (repl_start),
        .done  (repl_done),
        .pick  (repl_pick)
    );

    // Round the incoming offset down to the block size
    assign acc_off  = ADDR_BITS'(req.offset);
    assign acc_mask = (ADDR_BITS'(1) << shift_reg) - ADDR_BITS'(1);
    assign acc_tag  = acc_off & ~acc_mask;

    // Compare of the entry read last cycle
    assign rd_valid  = mem_rdata[ADDR_BITS];
    assign rd_tag    = mem_rdata[ADDR_BITS-1:0];
    assign rd_match  = rd_valid && (rd_tag == tag_reg);
    assign chk_last  = (chk_idx_reg == IDX_W'(ENTRIES - 1));
    assign scan_more = (rd_cnt_reg < (IDX_W + 1)'(ENTRIES));
    assign mem_raddr = rd_cnt_reg[IDX_W-1:0];

    assign out_free = !out_vld_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        rd_cnt_next  = rd_cnt_reg;
        chk_vld_next = 1'b0;
        cmd_next     = cmd_reg;
        tag_next     = tag_reg;
        res_hit_next = res_hit_reg;
        res_way_next = res_way_reg;
        res_mis_next = res_mis_reg;
        mem_we       = 1'b0;
        mem_waddr    = chk_idx_reg;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        repl_start   = 1'b0;
        out_load     = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we      = 1'b1;
                mem_waddr   = rd_cnt_reg[IDX_W-1:0];
                rd_cnt_next = rd_cnt_reg + (IDX_W + 1)'(1);
                if (rd_cnt_reg == (IDX_W + 1)'(ENTRIES - 1))
                begin
                    rd_cnt_next = '0;
                    state_next  = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next     = req.cmd;
                    tag_next     = acc_tag;
                    res_hit_next = 1'b0;
                    res_way_next = '0;
                    res_mis_next = 1'b0;
                    rd_cnt_next  = '0;
                    unique case (req.cmd) inside
                        CMD_LOOKUP, CMD_FILL:
                        begin
                            state_next = S_SCAN;
                        end
                        CMD_INVAL:
                        begin
                            if (acc_tag != acc_off)
                            begin
                                res_mis_next = 1'b1;
                                state_next   = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // issue the next read
                if (scan_more)
                begin
                    mem_re       = 1'b1;
                    rd_cnt_next  = rd_cnt_reg + (IDX_W + 1)'(1);
                    chk_vld_next = 1'b1;
                end
                // check the entry read last cycle
                if (chk_vld_reg)
                begin
                    case (cmd_reg)
                        CMD_LOOKUP:
                        begin
                            if (rd_match)
                            begin
                                res_hit_next = 1'b1;
                                res_way_next = chk_idx_reg;
                                state_next   = S_DONE;
                            end
                            else if (chk_last)
                            begin
                                state_next = S_DONE;
                            end
                        end
                        CMD_FILL:
                        begin
                            if (!rd_valid)
                            begin
                                mem_we       = 1'b1;
                                mem_wdata    = {1'b1, tag_reg};
                                res_hit_next = 1'b1;
                                res_way_next = chk_idx_reg;
                                state_next   = S_DONE;
                            end
                            else if (chk_last)
                            begin
                                repl_start = 1'b1;
                                state_next = S_MOD;
                            end
                        end
                        CMD_INVAL:
                        begin
                            if (rd_match)
                            begin
                                mem_we       = 1'b1;
                                mem_wdata    = {1'b0, rd_tag};
                                res_hit_next = 1'b1;
                            end
                            if (chk_last)
                            begin
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
                if (state_next != S_SCAN)
                begin
                    chk_vld_next = 1'b0;
                end
            end
            S_MOD:
            begin
                if (repl_done)
                begin
                    mem_we       = 1'b1;
                    mem_waddr    = repl_pick;
                    mem_wdata    = {1'b1, tag_reg};
                    res_hit_next = 1'b1;
                    res_way_next = repl_pick;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            rd_cnt_reg  <= '0;
            chk_vld_reg <= 1'b0;
            shift_reg   <= SHIFT_RST;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_cnt_reg  <= rd_cnt_next;
            chk_vld_reg <= chk_vld_next;
            if (cfg_we)
            begin
                shift_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Way number truncated to the field width
    assign way_x = WAY_X'(res_way_reg);

    // Payload
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        tag_reg     <= tag_next;
        res_hit_reg <= res_hit_next;
        res_way_reg <= res_way_next;
        res_mis_reg <= res_mis_next;
        if (mem_re)
        begin
            chk_idx_reg <= mem_raddr;
        end
        if (out_load)
        begin
            out_hit_reg <= res_hit_reg;
            out_way_reg <= way_x[WAY_W-1:0];
            out_mis_reg <= res_mis_reg;
        end
    end

    assign rsp.valid      = out_vld_reg;
    assign rsp.hit        = out_hit_reg;
    assign rsp.way        = out_way_reg;
    assign rsp.misaligned = out_mis_reg;

    // Read-modify-write never touches the entry being read
    a_rmw_sep: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we && mem_re |-> mem_waddr != mem_raddr)
        else $error("tag RAM write and read at the same entry");

    // Victim arrives only while waiting for it
    a_repl_state: assert property (@(posedge clk) disable iff (!rst_n)
        repl_done |-> state_reg == S_MOD)
        else $error("replacement result outside wait state");

    // Misaligned invalidate reports no match
    a_mis_nohit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.misaligned |-> !rsp.hit && rsp.way == '0)
        else $error("misaligned result carries hit or way");

    // A nonzero way only comes with a hit
    a_way_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.way != '0 |-> rsp.hit)
        else $error("way reported without hit");

endmodule

// ===== test/tag_store_checker.sv =====
`timescale 1ns / 1ps

// Passive monitor of the tag store: keeps its own copy of tags, valid bits,
// replacement LFSR and block shift, predicts one response per request
// transfer and compares each response transfer against the oldest prediction.
module tag_store_checker
    import brcts_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    brcts_req_if               req,
    brcts_rsp_if               rsp,
    input  logic               cfg_we,
    input  logic [SHIFT_W-1:0] cfg_wdata,
    output int                 mismatches,
    output int                 outstanding
);

    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] way;
        logic             misaligned;
    } cache_rsp_t;

    logic [OFFSET_W-1:0] tag_mem [ENTRIES];
    logic                line_valid [ENTRIES];
    logic [LFSR_W-1:0]   victim_lfsr;
    logic [SHIFT_W-1:0]  blk_shift;
    cache_rsp_t          awaited_rsp [$];
    cache_rsp_t          head_rsp;

    // Update the local copy of the store for one command, queue its response
    task automatic apply_cache_op(input logic [CMD_W-1:0] op, input logic [OFFSET_W-1:0] off);
        logic [63:0]         low;
        logic [OFFSET_W-1:0] tag;
        cache_rsp_t          r;
        int                  pick;
        low  = (64'd1 << blk_shift) - 64'd1;
        tag  = off & ~low[OFFSET_W-1:0];
        r    = '0;
        pick = -1;
        case (op)
            CMD_LOOKUP:
            begin
                // lowest valid way holding the tag wins
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (!r.hit && line_valid[i] && tag_mem[i] == tag)
                    begin
                        r.hit = 1'b1;
                        r.way = WAY_W'(i);
                    end
                end
            end
            CMD_FILL:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (pick < 0 && !line_valid[i])
                        pick = i;
                end
                // all ways valid: victim from the LFSR, then step it once
                if (pick < 0)
                begin
                    pick = int'(victim_lfsr) % ENTRIES;
                    if (victim_lfsr[0])
                        victim_lfsr = (victim_lfsr >> 1) ^ LFSR_TAPS;
                    else
                        victim_lfsr = victim_lfsr >> 1;
                end
                tag_mem[pick]    = tag;
                line_valid[pick] = 1'b1;
                r.hit            = 1'b1;
                r.way            = WAY_W'(pick);
            end
            CMD_INVAL:
            begin
                if (tag != off)
                    r.misaligned = 1'b1;
                else
                begin
                    // every matching copy goes, way field stays 0
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (line_valid[i] && tag_mem[i] == tag)
                        begin
                            line_valid[i] = 1'b0;
                            r.hit         = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        awaited_rsp.push_back(r);
    endtask

    function automatic void check_field(input string name, input logic [WAY_W-1:0] want,
                                        input logic [WAY_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                tag_mem[i]    = '0;
                line_valid[i] = 1'b0;
            end
            victim_lfsr = LFSR_SEED;
            blk_shift   = SHIFT_RST;
            awaited_rsp.delete();
            mismatches  = 0;
            outstanding <= 0;
        end
        else
        begin
            // response transfer: compare with the oldest prediction
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    $display("%0t: response with nothing expected, %s %0b way %0h misaligned %0b",
                             $time, "actual hit", rsp.hit, rsp.way, rsp.misaligned);
                    mismatches++;
                end
                else
                begin
                    head_rsp = awaited_rsp.pop_front();
                    check_field("hit", WAY_W'(head_rsp.hit), WAY_W'(rsp.hit));
                    check_field("way", head_rsp.way, rsp.way);
                    check_field("misaligned", WAY_W'(head_rsp.misaligned),
                                WAY_W'(rsp.misaligned));
                end
            end
            if (cfg_we)
                blk_shift = cfg_wdata;
            if (req.valid && req.ready)
                apply_cache_op(req.cmd, req.offset);
            outstanding <= awaited_rsp.size();
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import brcts_pkg::*;

    localparam logic [CMD_W-1:0]    CMD_UNUSED  = 2'd3;
    localparam logic [OFFSET_W-1:0] OFF_MAX     = '1;
    localparam int                  CLK_HALF    = 6;
    localparam int                  RESET_CYC   = 8;
    localparam int                  LONG_HOLD   = 1500;
    localparam int                  HOLD_EVERY  = 300;
    localparam int                  TAIL_CYC    = 300;
    localparam int                  CYCLE_LIMIT = 1500000;
    localparam int                  POOL_DEPTH  = 48;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [SHIFT_W-1:0] cfg_wdata;
    logic [SHIFT_W-1:0] cur_shift;
    int                 mismatches;
    int                 outstanding;
    int                 items_sent = 0;
    int                 holds_done = 0;
    int                 cycle_cnt  = 0;

    // recently filled offsets, reused so lookups and invalidates find something
    logic [OFFSET_W-1:0] fill_pool [$];

    brcts_req_if req ();
    brcts_rsp_if rsp ();

    block_read_cache_tag_store dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    tag_store_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // mostly short idle stretches, a few long ones
    function automatic int idle_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [OFFSET_W-1:0] rand_offset();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return OFF_MAX;
            default: return r[OFFSET_W-1:0];
        endcase
    endfunction

    // one request transfer, with an optional idle gap ahead of it
    task automatic send_op(input logic [CMD_W-1:0] op, input logic [OFFSET_W-1:0] off);
        int gap;
        gap = 0;
        if ((items_sent % 200) < 150 && $urandom_range(0, 2) == 0)
            gap = idle_len();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid  <= 1'b1;
        req.cmd    <= op;
        req.offset <= off;
        do @(posedge clk); while (!req.ready);
        items_sent <= items_sent + 1;
    endtask

    // stop sending, let every response arrive, then write the block shift
    task automatic set_shift(input logic [SHIFT_W-1:0] v);
        req.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_shift = v;
    endtask

    task automatic run_phase(input logic [SHIFT_W-1:0] shift, input int count,
                             input int pct_fill, input int pct_look, input int pct_inval);
        logic [CMD_W-1:0]    op;
        logic [OFFSET_W-1:0] off;
        logic [OFFSET_W-1:0] base;
        logic [OFFSET_W-1:0] low;
        logic [63:0]         m;
        int                  roll;
        set_shift(shift);
        m   = (64'd1 << cur_shift) - 64'd1;
        low = m[OFFSET_W-1:0];
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            if (fill_pool.size() > 0 && $urandom_range(0, 3) != 0)
                base = fill_pool[$urandom_range(0, fill_pool.size() - 1)];
            else
                base = rand_offset();
            if (roll < pct_fill)
            begin
                op = CMD_FILL;
                // mostly fresh blocks, sometimes a second copy of a known one
                if ($urandom_range(0, 4) == 0)
                    off = (base & ~low) | (rand_offset() & low);
                else
                    off = rand_offset();
                fill_pool.push_back(off);
                if (fill_pool.size() > POOL_DEPTH)
                    void'(fill_pool.pop_front());
            end
            else if (roll < pct_fill + pct_look)
            begin
                op  = CMD_LOOKUP;
                off = (base & ~low) | (rand_offset() & low);
            end
            else if (roll < pct_fill + pct_look + pct_inval)
            begin
                op  = CMD_INVAL;
                off = base & ~low;
                if ($urandom_range(0, 4) == 0)
                    off = off | (rand_offset() & low);
            end
            else
            begin
                op  = CMD_UNUSED;
                off = rand_offset();
            end
            send_op(op, off);
        end
    endtask

    // response side: random back-pressure plus long holds that stall the block
    initial
    begin
        rsp.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (holds_done < 2 && items_sent >= (holds_done + 1) * HOLD_EVERY)
            begin
                holds_done++;
                rsp.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                rsp.ready <= 1'b0;
                repeat (idle_len()) @(posedge clk);
            end
            else
            begin
                rsp.ready <= 1'b1;
                if ($urandom_range(0, 9) == 0)
                    repeat (300) @(posedge clk);
                else
                    repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    // request side and verdict
    initial
    begin
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_wdata  <= SHIFT_RST;
        req.valid  <= 1'b0;
        req.cmd    <= CMD_LOOKUP;
        req.offset <= '0;
        cur_shift  = SHIFT_RST;
        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset block shift of 4 KiB
        send_op(CMD_LOOKUP, '0);                  // empty store misses
        send_op(CMD_INVAL, '0);                   // aligned, nothing to clear
        send_op(CMD_FILL, '0);
        send_op(CMD_FILL, OFF_MAX);
        send_op(CMD_LOOKUP, 40'h00_0000_0FFF);
        send_op(CMD_LOOKUP, OFF_MAX);
        send_op(CMD_FILL, 40'h00_0000_0123);      // second copy of block 0
        send_op(CMD_LOOKUP, 40'h00_0000_0800);    // lowest copy reported
        send_op(CMD_INVAL, 40'h00_0000_0001);     // misaligned
        send_op(CMD_INVAL, '0);                   // drops both copies
        send_op(CMD_LOOKUP, '0);
        send_op(CMD_FILL, 40'h00_0000_5000);      // reuses lowest free way
        send_op(CMD_UNUSED, OFF_MAX);
        send_op(CMD_UNUSED, '0);
        send_op(CMD_INVAL, 40'hFF_FFFF_F000);
        send_op(CMD_INVAL, 40'hFF_FFFF_F000);     // already gone
        send_op(CMD_LOOKUP, 40'h00_0000_5ABC);
        send_op(CMD_INVAL, 40'h80_0000_0800);     // misaligned, top bit set
        send_op(CMD_FILL, 40'hAA_AAAA_A555);
        send_op(CMD_FILL, 40'h55_5555_5AAA);
        send_op(CMD_LOOKUP, 40'hAA_AAAA_A000);
        send_op(CMD_LOOKUP, 40'h55_5555_5FFF);

        // random phases; the fill-heavy one runs the store full into LFSR replacement
        run_phase(5'd9, 150, 45, 35, 17);
        run_phase(5'd16, 400, 85, 10, 4);
        run_phase(5'd0, 100, 30, 40, 27);
        run_phase(5'd31, 100, 30, 40, 27);
        run_phase(SHIFT_W'($urandom_range(9, 16)), 150, 40, 35, 22);

        req.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (TAIL_CYC) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
